### sv/eff_pkg.sv
`timescale 1ns / 1ps
// eff_pkg: shared types, constants and the crc-32 byte step for the ethernet frame filter
package eff_pkg;

    // longest frame that is not flagged as too long, preamble and fcs included
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int MIN_FRAME_BYTES = 26;
    localparam int PREAMBLE_BYTES  = 8;
    localparam int TYPE_HI_POS     = 20;
    localparam int TYPE_LO_POS     = 21;

    // byte counter saturates at MAX_FRAME_BYTES + 1
    localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int PLEN_W = 11;
    localparam int PLEN_LIMIT = (MAX_FRAME_BYTES - MIN_FRAME_BYTES > 2047) ?
                                2047 : (MAX_FRAME_BYTES - MIN_FRAME_BYTES);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]  PRE_BYTE = 8'h55;
    localparam logic [7:0]  SFD_BYTE = 8'hD5;
    localparam logic [15:0] ETHERTYPE_RESET = 16'h8ABC;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_SHORT     = 3'd1,
        STAT_PREAMBLE  = 3'd2,
        STAT_ETHERTYPE = 3'd3,
        STAT_CRC       = 3'd4,
        STAT_TOO_LONG  = 3'd5
    } eff_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_last;
    } eff_in_t;

    typedef struct packed {
        eff_status_t        frame_status;
        logic [PLEN_W-1:0]  payload_length;
    } eff_out_t;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/eff_frame_check.sv
`timescale 1ns / 1ps
// eff_frame_check: per-frame state, crc accumulation and the verdict logic
module eff_frame_check
    import eff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  eff_in_t     beat,
    input  logic [15:0] ethertype,
    output logic        res_valid,
    output eff_out_t    result
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      crc_reg, crc_next;
    logic [7:0]       tail_reg [4];
    logic [7:0]       tail_next [4];
    logic             pre_good_reg, pre_good_next;
    logic [7:0]       type_hi_reg, type_hi_next;
    logic             type_match_reg, type_match_next;

    logic [31:0]      fcs;
    logic [IDX_W-1:0] plen_full;
    logic [7:0]       want;

    always_comb begin
        want          = (idx_reg == IDX_W'(PREAMBLE_BYTES - 1)) ? SFD_BYTE : PRE_BYTE;
        pre_good_next = pre_good_reg;
        if (idx_reg < IDX_W'(PREAMBLE_BYTES) && beat.rx_byte != want) begin
            pre_good_next = 1'b0;
        end

        type_hi_next = (idx_reg == IDX_W'(TYPE_HI_POS)) ? beat.rx_byte : type_hi_reg;
        type_match_next = type_match_reg;
        if (idx_reg == IDX_W'(TYPE_LO_POS)) begin
            type_match_next = ({type_hi_reg, beat.rx_byte} == ethertype);
        end

        // byte leaving the delay line feeds the crc once past the preamble
        crc_next = crc_reg;
        if (idx_reg >= IDX_W'(PREAMBLE_BYTES + 4)) begin
            crc_next = crc32_byte(crc_reg, tail_reg[0]);
        end

        tail_next[0] = tail_reg[1];
        tail_next[1] = tail_reg[2];
        tail_next[2] = tail_reg[3];
        tail_next[3] = beat.rx_byte;

        idx_next = (idx_reg != IDX_W'(MAX_FRAME_BYTES + 1)) ? idx_reg + 1'b1 : idx_reg;

        fcs       = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};
        plen_full = idx_next - IDX_W'(MIN_FRAME_BYTES);

        if (idx_next < IDX_W'(MIN_FRAME_BYTES)) begin
            result.frame_status = STAT_SHORT;
        end else if (!pre_good_next) begin
            result.frame_status = STAT_PREAMBLE;
        end else if (!type_match_next) begin
            result.frame_status = STAT_ETHERTYPE;
        end else if (~crc_next != fcs) begin
            result.frame_status = STAT_CRC;
        end else if (idx_next > IDX_W'(MAX_FRAME_BYTES)) begin
            result.frame_status = STAT_TOO_LONG;
        end else begin
            result.frame_status = STAT_OK;
        end

        if (idx_next < IDX_W'(MIN_FRAME_BYTES)) begin
            result.payload_length = '0;
        end else if (plen_full > IDX_W'(PLEN_LIMIT)) begin
            result.payload_length = PLEN_W'(PLEN_LIMIT);
        end else begin
            result.payload_length = PLEN_W'(plen_full);
        end

        res_valid = advance && beat.frame_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && beat.frame_last)) begin
            idx_reg        <= '0;
            crc_reg        <= CRC_INIT;
            tail_reg       <= '{default: 8'd0};
            pre_good_reg   <= 1'b1;
            type_hi_reg    <= 8'd0;
            type_match_reg <= 1'b0;
        end else if (advance) begin
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
            tail_reg       <= tail_next;
            pre_good_reg   <= pre_good_next;
            type_hi_reg    <= type_hi_next;
            type_match_reg <= type_match_next;
        end
    end

endmodule

### sv/ethernet_frame_filter_crc32.sv
`timescale 1ns / 1ps
// ethernet_frame_filter_crc32: top level with input register, config register and result register
//
//  channel   | ports                          | moves
//  ----------+--------------------------------+-------------------------------------
//  input     | s_valid s_ready s_beat         | one received byte + last flag a beat
//  result    | m_valid m_ready m_result       | one verdict beat per frame
//  config    | cfg_wr_en cfg_wr_data          | accepted ethertype, no wait
//
// one input beat a cycle while no last beat waits on a held verdict; each beat passes the input register,
// the verdict of a frame shows on m_result the cycle after its last beat is processed
// the crc-32 byte step lies between the frame state and the verdict logic and result register
// aresetn is synchronous, active low; it clears frame state and sets the ethertype to 0x8abc
// a held verdict stalls the next last beat in the input register and the beats behind it; earlier beats flow on
module ethernet_frame_filter_crc32
    import eff_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  eff_in_t     s_beat,
    output logic        m_valid,
    input  logic        m_ready,
    output eff_out_t    m_result,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // input register
    logic     in_valid_reg;
    eff_in_t  in_beat_reg;

    // config register
    logic [15:0] ethertype_reg;

    // result register
    logic     m_valid_reg;
    eff_out_t m_result_reg;

    logic     advance;
    logic     res_valid;
    eff_out_t result;

    // a last beat waits only while an untaken verdict sits in the result register
    assign advance = in_valid_reg && (!in_beat_reg.frame_last || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_beat_reg <= s_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ethertype_reg <= ETHERTYPE_RESET;
        end else if (cfg_wr_en) begin
            ethertype_reg <= cfg_wr_data;
        end
    end

    eff_frame_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .beat      (in_beat_reg),
        .ethertype (ethertype_reg),
        .res_valid (res_valid),
        .result    (result)
    );

    // verdict register, freed when the downstream takes the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_result_reg <= result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

`ifndef SYNTHESIS
    // short frames report no payload
    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_result_reg.frame_status == STAT_SHORT
        |-> m_result_reg.payload_length == '0)
        else $error("short frame with nonzero payload length");

    // too-long frames report the saturated length
    a_long_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_result_reg.frame_status == STAT_TOO_LONG
        |-> m_result_reg.payload_length == PLEN_W'(PLEN_LIMIT))
        else $error("too-long frame without saturated length");

    // a stalled beat in the input register is held
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_beat_reg))
        else $error("input register lost a stalled beat");

    // a new verdict comes only from a processed last beat
    a_res_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance && in_beat_reg.frame_last))
        else $error("verdict without a last beat");

    // a verdict never overwrites one that was not taken
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !m_valid_reg || m_ready)
        else $error("verdict overrun");
`endif

endmodule
